// File: hw/rtl/sha512_hash_engine_unit_assert.svh
// Assertion macros for the SHA-512 engine checker.
// Used by the checker file only.
`ifndef SHA512_HASH_ENGINE_UNIT_ASSERT_SVH
`define SHA512_HASH_ENGINE_UNIT_ASSERT_SVH
`define SHA_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sha512 check failed");
`define SHA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sha512 check failed");
`endif

// File: hw/rtl/sha512_pkg.sv
// Package for the SHA-512 engine: round constants, initial hash, helpers.
// No dependencies.
`timescale 1ns / 1ps
package sha512_pkg;
  typedef logic [63:0] word_t;

  localparam word_t ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t INIT_H [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t PAD_MARK = 64'h8000_0000_0000_0000;
  localparam logic [3:0] FULL_BYTES = 4'd8;
  localparam logic [3:0] LEN_SLOT = 4'd14;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

  typedef struct packed {
    logic  start;
    logic  busy;
    logic  done;
  } rnd_ctl_t;
endpackage

// File: hw/rtl/sha512_round.sv
// SHA-512 compression unit: one round per cycle, in place schedule window.
// Depends on sha512_pkg.
`timescale 1ns / 1ps
module sha512_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  sha512_pkg::word_t    blk [16],
  input  sha512_pkg::word_t    hin [8],
  output sha512_pkg::word_t    hout [8],
  output sha512_pkg::rnd_ctl_t ctl
);
  sha512_pkg::word_t w_r [16];
  sha512_pkg::word_t v_r [8];
  logic [6:0] t_r;
  logic busy_r, done_r;
  sha512_pkg::word_t wt, s0, s1, t1, t2, a2, a15;
  logic [3:0] ti;

  always_comb begin
    ti  = t_r[3:0];
    a2  = w_r[4'(ti - 4'd2)];
    a15 = w_r[4'(ti - 4'd15)];
    s1  = sha512_pkg::rotr(a2, 19) ^ sha512_pkg::rotr(a2, 61) ^ (a2 >> 6);
    s0  = sha512_pkg::rotr(a15, 1) ^ sha512_pkg::rotr(a15, 8) ^ (a15 >> 7);
    wt  = (t_r < 7'd16) ? w_r[ti] : s1 + w_r[4'(ti - 4'd7)] + s0 + w_r[ti];
    t1  = v_r[7] + (sha512_pkg::rotr(v_r[4], 14) ^ sha512_pkg::rotr(v_r[4], 18)
          ^ sha512_pkg::rotr(v_r[4], 41)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
          + sha512_pkg::ROUND_K[t_r] + wt;
    t2  = (sha512_pkg::rotr(v_r[0], 28) ^ sha512_pkg::rotr(v_r[0], 34)
          ^ sha512_pkg::rotr(v_r[0], 39))
          + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      t_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        t_r    <= '0;
      end else if (busy_r) begin
        if (t_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        t_r <= t_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_r <= blk;
      v_r <= hin;
    end else if (busy_r) begin
      w_r[ti] <= wt;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign hout = v_r;
  assign ctl  = '{start: start, busy: busy_r, done: done_r};
endmodule

// File: hw/rtl/sha512_hash_engine_unit.sv
// Channel   | Beat content                                  | Handshake
// in_       | tdata: msg_word, byte_count; tuser: last_word | tvalid/tready
// out_      | tdata: digest_word, digest_index; tlast       | tvalid/tready
// A word is stored as it is accepted. The 16th word of a block holds in_tready low through
// the start, the 80 rounds and the fold into the hash: no new word is accepted until the
// block is compressed, so the round unit sets the sustained rate.
// A last word adds padding words, one per cycle, with one or two compressions,
// then eight digest beats, one per cycle while out_tready is high.
// Reset (rst_n, synchronous) restores initial hash; in_tready low while busy.
// Depends on sha512_pkg and sha512_round.
`timescale 1ns / 1ps
module sha512_hash_engine_unit #(
  parameter int LENGTH_COUNT_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] msg_word, [67:64] byte_count, rest zero
  input  logic        in_tuser,   // [0] last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] digest_word, [66:64] digest_index, rest zero
  output logic        out_tlast
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_PAD = 4'b0010, S_COMP = 4'b0100, S_SEND = 4'b1000
  } st_t;

  st_t st_r;
  sha512_pkg::word_t blk_r [16];
  sha512_pkg::word_t h_r [8];
  sha512_pkg::word_t hout [8];
  logic [3:0]  idx_r;
  logic [60:0] tot_r;
  logic        pad_r, fin_r, lenok_r, go_r, start;
  logic [2:0]  oi_r;
  sha512_pkg::rnd_ctl_t rc;
  sha512_pkg::word_t wd, pw, lenw;
  logic [3:0] cnt;
  logic [63:0] bits;
  logic acc;

  sha512_round u_rnd (.clk, .rst_n, .start, .blk(blk_r), .hin(h_r), .hout, .ctl(rc));

  assign in_tready = (st_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign start = go_r;
  assign cnt = in_tuser ? ((in_tdata[67:64] > sha512_pkg::FULL_BYTES)
               ? sha512_pkg::FULL_BYTES : in_tdata[67:64]) : sha512_pkg::FULL_BYTES;
  assign bits = {tot_r, 3'b000} & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_COUNT_BITS));

  always_comb begin
    wd = in_tdata[63:0];
    if (in_tuser && cnt != sha512_pkg::FULL_BYTES)
      wd = (in_tdata[63:0] & ~(64'hFFFF_FFFF_FFFF_FFFF >> {cnt, 3'b000}))
           | (sha512_pkg::PAD_MARK >> {cnt, 3'b000});
    lenw = (idx_r == 4'd15 && lenok_r) ? bits : 64'd0;
    pw = pad_r ? sha512_pkg::PAD_MARK : lenw;
  end

  always_ff @(posedge clk) begin
    if (acc) blk_r[idx_r] <= wd;
    else if (st_r == S_PAD) blk_r[idx_r] <= pw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; idx_r <= '0; tot_r <= '0; pad_r <= 1'b0; fin_r <= 1'b0;
      lenok_r <= 1'b0; oi_r <= '0; go_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::INIT_H[i];
    end else begin
      go_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (acc) begin
            idx_r <= idx_r + 4'd1;
            tot_r <= tot_r + 61'(cnt);
            fin_r <= in_tuser;
            pad_r <= in_tuser && (cnt == sha512_pkg::FULL_BYTES);
            lenok_r <= in_tuser && (cnt != sha512_pkg::FULL_BYTES)
                       && (idx_r < sha512_pkg::LEN_SLOT);
            if (idx_r == 4'd15) begin
              st_r <= S_COMP; go_r <= 1'b1;
            end else if (in_tuser) begin
              st_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          idx_r <= idx_r + 4'd1;
          pad_r <= 1'b0;
          if (pad_r) lenok_r <= (idx_r < sha512_pkg::LEN_SLOT);
          if (idx_r == 4'd15) begin
            st_r <= S_COMP; go_r <= 1'b1;
          end
        end
        S_COMP: begin
          if (rc.done) begin
            for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + hout[i];
            if (!fin_r) begin
              st_r <= S_IDLE;
            end else if (lenok_r && !pad_r) begin
              st_r <= S_SEND; oi_r <= '0;
            end else begin
              st_r <= S_PAD;
              if (!pad_r) lenok_r <= 1'b1;
            end
          end
        end
        S_SEND: begin
          if (out_tready) begin
            oi_r <= oi_r + 3'd1;
            if (oi_r == 3'd7) begin
              st_r <= S_IDLE; tot_r <= '0; fin_r <= 1'b0; lenok_r <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::INIT_H[i];
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = (st_r == S_SEND);
  assign out_tdata  = {5'd0, oi_r, h_r[oi_r]};
  assign out_tlast  = (oi_r == 3'd7);
endmodule

// File: hw/rtl/sha512_chk.sv
// Port-level checker for the SHA-512 engine, bound to the top level.
// Depends on sha512_hash_engine_unit_assert.svh.
`timescale 1ns / 1ps
`include "sha512_hash_engine_unit_assert.svh"
module sha512_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);
  `SHA_ASSERT_IMPL(a_no_overlap, out_tvalid, !in_tready)
  `SHA_ASSERT_IMPL(a_last_idx, out_tvalid && out_tlast, out_tdata[66:64] == 3'd7)
  `SHA_ASSERT_NEXT(a_idx_step, out_tvalid && out_tready && !out_tlast,
    out_tvalid && out_tdata[66:64] == $past(out_tdata[66:64]) + 3'd1)
  `SHA_ASSERT_IMPL(a_pad_zero, out_tvalid, out_tdata[71:67] == 5'd0)
endmodule

bind sha512_hash_engine_unit sha512_chk u_chk (.clk, .rst_n, .in_tready, .out_tvalid,
  .out_tready, .out_tdata, .out_tlast);

// File: tb/sv/sha512_hash_engine_unit_tb.sv
// Testbench for sha512_hash_engine_unit: streams message words, predicts the
// SHA-512 digest beats with a local model and checks every output beat.
// Depends on sha512_pkg for the round constants and initial hash values.
`timescale 1ns / 1ps
module sha512_hash_engine_unit_tb;
  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  sha512_pkg::word_t hash_st [8];
  sha512_pkg::word_t sched [16];
  logic [3:0]   slot;
  logic [60:0]  byte_total;
  digest_beat_t digest_q [$];
  int           mismatches = 0;
  int           cycles = 0;
  int           burst_left = 0;

  sha512_hash_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  function automatic sha512_pkg::word_t ror(sha512_pkg::word_t v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  task automatic compress();
    sha512_pkg::word_t v [8];
    sha512_pkg::word_t w, t1, t2, a2, a15;
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        a2 = sched[(t - 2) & 15];
        a15 = sched[(t - 15) & 15];
        w = (ror(a2, 19) ^ ror(a2, 61) ^ (a2 >> 6)) + sched[(t - 7) & 15]
          + (ror(a15, 1) ^ ror(a15, 8) ^ (a15 >> 7)) + sched[t & 15];
        sched[t & 15] = w;
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::ROUND_K[t] + w;
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic push_word(sha512_pkg::word_t w);
    sched[slot] = w;
    slot = slot + 4'd1;
    if (slot == 0) compress();
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) hash_st[i] = sha512_pkg::INIT_H[i];
    slot = '0;
    byte_total = '0;
  endtask

  task automatic predict_digest(sha512_pkg::word_t word, logic [3:0] cnt_in, logic last);
    logic [3:0]  cnt;
    sha512_pkg::word_t keep;
    logic [63:0] bits;
    digest_beat_t b;
    if (!last) begin
      byte_total = byte_total + 61'd8;
      push_word(word);
      return;
    end
    cnt = (cnt_in > sha512_pkg::FULL_BYTES) ? sha512_pkg::FULL_BYTES : cnt_in;
    byte_total = byte_total + 61'(cnt);
    if (cnt == sha512_pkg::FULL_BYTES) begin
      push_word(word);
      push_word(sha512_pkg::PAD_MARK);
    end else begin
      keep = (cnt == 0) ? '0 : ~64'h0 << (64 - 8 * cnt);
      push_word((word & keep) | (64'h80 << (56 - 8 * cnt)));
    end
    while (slot != sha512_pkg::LEN_SLOT) push_word('0);
    bits = {byte_total, 3'b000};
    push_word('0);
    push_word(bits);
    for (int i = 0; i < 8; i++) begin
      b.word = hash_st[i];
      b.index = i[2:0];
      b.last = (i == 7);
      digest_q.push_back(b);
    end
    clear_hash();
  endtask

  task automatic send_word(sha512_pkg::word_t word, logic [3:0] cnt, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, cnt, word};
    in_tuser <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_digest(word, cnt, last);
    @(negedge clk);
  endtask

  function automatic sha512_pkg::word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_message(int full_words, logic [3:0] cnt);
    for (int i = 0; i < full_words; i++)
      send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
    send_word(rand_word(), cnt, 1'b1);
  endtask

  task automatic test_directed();
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word(64'h6162_6300_0000_0000, 4'd3, 1'b1);
    send_word('1, 4'd15, 1'b1);
    send_word('1, 4'd1, 1'b1);
    send_word(rand_word(), 4'd3, 1'b0);
    send_word('1, 4'd7, 1'b1);
    send_message(13, 4'd8);
    send_message(14, 4'd0);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 90) begin
      int n;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 33) : $urandom_range(0, 4);
      send_message(n, 4'($urandom_range(0, 15)));
      sent += n + 1;
    end
  endtask

  always @(negedge clk) begin
    case ($urandom_range(0, 3))
      0: out_tready <= 1'b0;
      default: out_tready <= ((cycles / 200) % 3 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    digest_beat_t exp_b;
    cycles++;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_tdata);
      end else begin
        exp_b = digest_q.pop_front();
        if (out_tdata[63:0] !== exp_b.word || out_tdata[66:64] !== exp_b.index ||
            out_tdata[71:67] !== '0 || out_tlast !== exp_b.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h/%0d/%b got %h/%0d/%b", exp_b.word, exp_b.index,
                     exp_b.last, out_tdata[63:0], out_tdata[66:64], out_tlast);
        end
      end
    end
  end

  initial begin
    clear_hash();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
